// File: sv/gbdt_pkg.sv
// shared types and constants for the graph traversal block
`timescale 1ns / 1ps
package gbdt_pkg;
    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [1:0] COL_WHITE = 2'd0;
    localparam logic [1:0] COL_GRAY  = 2'd1;
    localparam logic [1:0] COL_BLACK = 2'd2;
    localparam logic [5:0] UNREACHED = 6'd63;
    localparam logic [5:0] TIME_MAX  = 6'd62;
endpackage

// File: sv/graph_bfs_dfs_traversal.sv
// top level of the graph traversal block: edge store, bfs and dfs sequencer
`timescale 1ns / 1ps
// Directed-graph traversal engine. Add beats append an edge to the source vertex's
// neighbor list in a synchronous memory, and clear beats empty all lists through
// per-vertex fill counts; both can be accepted every cycle while the block is idle.
// A run beat performs breadth-first search from i_start_vertex or depth-first
// search over all vertices (i_walk_mode register) and then emits one result beat
// per reported vertex in index order. A run first resets the per-vertex result
// table entry by entry. Breadth-first search then seeds the queue with the start
// vertex, and for each dequeued vertex examines its edges one at a time and then
// marks it black, until a final check finds the queue empty. Depth-first search
// checks each root candidate in turn, examines the edges of the vertex on top of
// the stack one at a time and finishes a vertex once its edges are exhausted.
// Results stream as min(NUM_VERTICES,16) beats, each held by any sink stall.
// Input is stalled from the run beat until its last result beat has been accepted.
module graph_bfs_dfs_traversal
    import gbdt_pkg::*;
#(
    parameter int NUM_VERTICES = 16,
    parameter int MAX_DEGREE   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_walk_mode,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_action,
    input  logic [3:0] i_from_vertex,
    input  logic [3:0] i_to_vertex,
    input  logic [3:0] i_start_vertex,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_vertex_id,
    output logic [5:0] o_discover_value,
    output logic [5:0] o_finish_time,
    output logic [3:0] o_parent_vertex,
    output logic       o_has_parent,
    output logic [1:0] o_final_color,
    output logic       o_last_result
);
    localparam int VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam int SW = $clog2(NUM_VERTICES + 1);
    localparam int NREP = (NUM_VERTICES < 16) ? NUM_VERTICES : 16;
    localparam logic [VW-1:0] LAST_V = VW'(NUM_VERTICES - 1);
    localparam logic [VW-1:0] LAST_R = VW'(NREP - 1);
    localparam logic [SW-1:0] NV_S = SW'(NUM_VERTICES);
    localparam logic [CW-1:0] MAXD = CW'(MAX_DEGREE);

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_BFS_SEED, S_BFS_POP, S_BFS_DEQ, S_BFS_EDGE, S_BFS_RD,
        S_BFS_UPD, S_BFS_FIN, S_DFS_ROOT, S_DFS_RCHK, S_DFS_TOP, S_DFS_EDGE,
        S_DFS_RD, S_DFS_UPD, S_DFS_FIN, S_OUT_RD, S_OUT_SEND
    } t_state;

    typedef struct packed {
        logic [5:0]    disc;
        logic [5:0]    fin;
        logic          has_p;
        logic [VW-1:0] par;
        logic [1:0]    col;
    } t_vrec;

    // memories
    logic [VW-1:0] nbr_mem [NUM_VERTICES*MAX_DEGREE];
    t_vrec         vtx_mem [NUM_VERTICES];
    logic [VW-1:0] que_mem [NUM_VERTICES];
    logic [VW-1:0] stk_v   [NUM_VERTICES];
    logic [CW-1:0] stk_k   [NUM_VERTICES];
    logic [CW-1:0] r_cnt   [NUM_VERTICES];

    t_state        r_state;
    logic          r_mode;
    logic [VW-1:0] r_idx;     // init / root / output index
    logic [SW-1:0] r_head, r_tail, r_sp;
    logic [VW-1:0] r_v;       // current vertex
    logic [CW-1:0] r_k;       // current edge index
    logic [5:0]    r_vdisc;   // dist of vertex being expanded
    logic [5:0]    r_time;
    logic [VW-1:0] r_start;   // bfs source
    logic          r_start_ok;
    logic [VW-1:0] r_w;       // neighbor read result
    t_vrec         r_rec;     // vtx read data
    logic [VW-1:0] r_qrd;
    logic          r_ovalid;
    t_vrec         r_orec;
    logic [3:0]    r_oid;
    logic          r_olast;

    // neighbor address
    function automatic logic [VW+DW-1:0] naddr(logic [VW-1:0] v, logic [DW-1:0] k);
        naddr = (VW+DW)'(v) * (VW+DW)'(MAX_DEGREE) + (VW+DW)'(k);
    endfunction

    logic [5:0] tick_v;
    assign tick_v = (r_time < TIME_MAX) ? r_time + 6'd1 : r_time;

    logic acc_in;
    logic out_free;
    logic add_ok;
    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign acc_in      = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign out_free    = !r_ovalid || !i_stall;
    assign add_ok      = acc_in && t_action'(i_action) == ACT_ADD
                         && 32'(i_from_vertex) < NUM_VERTICES
                         && 32'(i_to_vertex) < NUM_VERTICES
                         && r_cnt[VW'(i_from_vertex)] < MAXD;

    // edge count and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            for (int i = 0; i < NUM_VERTICES; i++) r_cnt[i] <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_mode <= i_walk_mode;
            if (acc_in && t_action'(i_action) == ACT_CLEAR) begin
                for (int i = 0; i < NUM_VERTICES; i++) r_cnt[i] <= '0;
            end else if (add_ok) begin
                r_cnt[VW'(i_from_vertex)] <= r_cnt[VW'(i_from_vertex)] + 1'b1;
            end
        end
    end

    // neighbor store write / read
    logic [VW+DW-1:0] nrd_addr;
    always_ff @(posedge i_clk) begin
        if (add_ok)
            nbr_mem[naddr(VW'(i_from_vertex), DW'(r_cnt[VW'(i_from_vertex)]))]
                <= VW'(i_to_vertex);
        r_w <= nbr_mem[nrd_addr];
    end

    // vertex table: one write and one read port
    logic          vwe;
    logic [VW-1:0] vwa, vra;
    t_vrec         vwd;
    always_ff @(posedge i_clk) begin
        if (vwe) vtx_mem[vwa] <= vwd;
        r_rec <= vtx_mem[vra];
    end

    // work queue
    logic          qwe;
    logic [VW-1:0] qwd;
    always_ff @(posedge i_clk) begin
        if (qwe) que_mem[r_tail[VW-1:0]] <= qwd;
        r_qrd <= que_mem[r_head[VW-1:0]];
    end

    // top of stack pointer and its edge cursor (small register stack)
    logic [VW-1:0] top_i;
    assign top_i = VW'(r_sp - 1'b1);

    logic          skwe, svwe;
    logic [VW-1:0] swa;
    logic [CW-1:0] skd;
    logic [VW-1:0] svd;
    always_ff @(posedge i_clk) begin
        if (svwe) stk_v[swa] <= svd;
        if (skwe) stk_k[swa] <= skd;
    end

    // address and write control
    always_comb begin
        vwe = 1'b0; vwa = r_idx; vwd = r_rec; vra = r_idx;
        qwe = 1'b0; qwd = r_w;
        svwe = 1'b0; skwe = 1'b0; swa = top_i; skd = r_k; svd = r_w;
        nrd_addr = naddr(r_v, DW'(r_k));
        case (r_state)
            S_INIT: begin
                vwe = 1'b1;
                vwd = '{disc: UNREACHED, fin: 6'd0, has_p: 1'b0, par: '0, col: COL_WHITE};
            end
            S_BFS_SEED: begin
                vwe = 1'b1; vwa = r_start;
                vwd = '{disc: 6'd0, fin: 6'd0, has_p: 1'b0, par: '0, col: COL_GRAY};
                qwe = 1'b1; qwd = r_start;
            end
            S_BFS_EDGE: vra = r_v;
            S_BFS_RD:   vra = r_w;
            S_BFS_UPD: begin
                if (r_rec.col == COL_WHITE && r_tail < NV_S) begin
                    vwe = 1'b1; vwa = r_w;
                    vwd = '{disc: (r_vdisc < TIME_MAX) ? r_vdisc + 6'd1 : TIME_MAX,
                            fin: 6'd0, has_p: 1'b1, par: r_v, col: COL_GRAY};
                    qwe = 1'b1;
                end
            end
            S_BFS_FIN: begin
                vwe = 1'b1; vwa = r_v;
                vwd = r_rec; vwd.col = COL_BLACK;
            end
            S_DFS_RCHK: begin
                if (r_rec.col == COL_WHITE) begin
                    vwe = 1'b1; vwa = r_idx;
                    vwd = '{disc: tick_v, fin: 6'd0, has_p: 1'b0, par: '0, col: COL_GRAY};
                    svwe = 1'b1; skwe = 1'b1; swa = '0; svd = r_idx; skd = '0;
                end
            end
            S_DFS_EDGE: begin
                vra = r_v;
                if (r_k < r_cnt[r_v]) begin
                    skwe = 1'b1; skd = r_k + 1'b1;
                end
            end
            S_DFS_RD:   vra = r_w;
            S_DFS_UPD: begin
                if (r_rec.col == COL_WHITE && r_sp < NV_S) begin
                    vwe = 1'b1; vwa = r_w;
                    vwd = '{disc: tick_v, fin: 6'd0, has_p: 1'b1, par: r_v, col: COL_GRAY};
                    svwe = 1'b1; skwe = 1'b1; swa = VW'(r_sp); svd = r_w; skd = '0;
                end
            end
            S_DFS_FIN: begin
                vwe = 1'b1; vwa = r_v;
                vwd = r_rec; vwd.col = COL_BLACK; vwd.fin = tick_v;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_idx <= '0; r_head <= '0; r_tail <= '0; r_sp <= '0;
            r_time <= '0; r_v <= '0; r_k <= '0; r_vdisc <= '0;
            r_start <= '0; r_start_ok <= 1'b0;
        end else begin
            if (r_state == S_OUT_SEND && out_free) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc_in && t_action'(i_action) == ACT_RUN) begin
                        r_state <= S_INIT; r_idx <= '0; r_time <= '0;
                        r_head <= '0; r_tail <= '0; r_sp <= '0;
                        r_start <= VW'(i_start_vertex);
                        r_start_ok <= (32'(i_start_vertex) < NUM_VERTICES);
                    end
                end
                S_INIT: begin
                    if (r_idx == LAST_V) begin
                        r_idx <= '0;
                        if (r_mode) r_state <= S_DFS_ROOT;
                        else if (r_start_ok) r_state <= S_BFS_SEED;
                        else r_state <= S_OUT_RD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // seed the queue with the start vertex
                S_BFS_SEED: begin
                    r_tail  <= SW'(1);
                    r_state <= S_BFS_POP;
                end
                S_BFS_POP: begin
                    if (r_head == r_tail) begin
                        r_state <= S_OUT_RD; r_idx <= '0;
                    end else begin
                        r_state <= S_BFS_DEQ;
                    end
                end
                S_BFS_DEQ: begin
                    r_v <= r_qrd; r_k <= '0;
                    r_head <= r_head + 1'b1;
                    r_state <= S_BFS_EDGE;
                end
                S_BFS_EDGE: begin
                    if (r_k < r_cnt[r_v]) r_state <= S_BFS_RD;
                    else r_state <= S_BFS_FIN;
                end
                S_BFS_RD: begin
                    r_vdisc <= r_rec.disc;
                    r_state <= S_BFS_UPD;
                end
                S_BFS_UPD: begin
                    if (r_rec.col == COL_WHITE && r_tail < NV_S) r_tail <= r_tail + 1'b1;
                    r_k <= r_k + 1'b1;
                    r_state <= S_BFS_EDGE;
                end
                S_BFS_FIN: r_state <= S_BFS_POP;
                S_DFS_ROOT: r_state <= S_DFS_RCHK;
                S_DFS_RCHK: begin
                    if (r_rec.col == COL_WHITE) begin
                        r_time <= tick_v; r_sp <= SW'(1);
                        r_state <= S_DFS_TOP;
                    end else if (r_idx == LAST_V) begin
                        r_idx <= '0; r_state <= S_OUT_RD;
                    end else begin
                        r_idx <= r_idx + 1'b1; r_state <= S_DFS_ROOT;
                    end
                end
                S_DFS_TOP: begin
                    r_v <= stk_v[top_i]; r_k <= stk_k[top_i];
                    r_state <= S_DFS_EDGE;
                end
                S_DFS_EDGE: begin
                    if (r_k < r_cnt[r_v]) r_state <= S_DFS_RD;
                    else r_state <= S_DFS_FIN;
                end
                S_DFS_RD: r_state <= S_DFS_UPD;
                S_DFS_UPD: begin
                    if (r_rec.col == COL_WHITE && r_sp < NV_S) begin
                        r_time <= tick_v; r_sp <= r_sp + 1'b1;
                    end
                    r_state <= S_DFS_TOP;
                end
                S_DFS_FIN: begin
                    r_time <= tick_v;
                    r_sp <= r_sp - 1'b1;
                    if (r_sp != SW'(1)) r_state <= S_DFS_TOP;
                    else if (r_idx == LAST_V) begin
                        r_idx <= '0; r_state <= S_OUT_RD;
                    end else begin
                        r_idx <= r_idx + 1'b1; r_state <= S_DFS_ROOT;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_SEND;
                S_OUT_SEND: begin
                    if (out_free) begin
                        if (r_idx == LAST_R) begin
                            r_idx <= '0; r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1; r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_vertex_id = r_oid;
    assign o_discover_value = r_orec.disc;
    assign o_finish_time = r_orec.fin;
    assign o_parent_vertex = r_orec.has_p ? 4'(r_orec.par) : 4'd0;
    assign o_has_parent = r_orec.has_p;
    assign o_final_color = r_orec.col;
    assign o_last_result = r_olast;
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT_SEND && out_free) begin
            r_orec <= '{disc: r_rec.disc, fin: r_mode ? r_rec.fin : 6'd0,
                        has_p: r_rec.has_p, par: r_rec.par, col: r_rec.col};
            r_oid <= 4'(r_idx); r_olast <= (r_idx == LAST_R);
        end
    end

    // output register only loads when free
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_vertex_id)) else $error("out");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall) else $error("busy");
endmodule
